@@ rtl/wfac_pkg.sv @@
`timescale 1ns / 1ps

package wfac_pkg;

  localparam int PRE_STAGES   = 3;
  localparam int ITER_STAGES  = 21;
  localparam int STEPS_PER    = 2;
  localparam int SQ_STEPS     = 25;
  localparam int REP_STEPS    = 15;
  localparam int RATIO_STEPS  = 10;
  localparam int CDIV_STEPS   = 16;
  localparam int ST_CHOOSE    = PRE_STAGES + ITER_STAGES;
  localparam int ST_SELECT    = ST_CHOOSE + 1;
  localparam int ST_ERROR     = ST_CHOOSE + 2;
  localparam int ST_GAIN      = ST_CHOOSE + 3;
  localparam int ST_DIV5_0    = ST_CHOOSE + 4;
  localparam int ST_FINAL     = ST_CHOOSE + 5;
  localparam int NUM_STAGES   = ST_FINAL + 1;

  localparam logic [2:0] REG_VALID_RANGE  = 3'd0;
  localparam logic [2:0] REG_DANGER_RANGE = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED    = 3'd2;
  localparam logic [2:0] REG_RATIO_LIMIT  = 3'd3;
  localparam logic [2:0] REG_TURN_GAIN    = 3'd4;
  localparam logic [2:0] REG_DEFAULT_WALL = 3'd5;
  localparam logic [2:0] REG_MAX_WIDTH    = 3'd6;
  localparam logic [2:0] REG_AVOID_GAIN   = 3'd7;

  localparam logic [1:0] SIDE_LEFT  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_NONE  = 2'd2;

  // floor(mm / 10) == (mm * 52429) >> 19 for 16-bit mm
  localparam logic [16:0] CM_RECIP = 17'd52429;
  // floor(x / 5) == (x * 13421773) >> 26 for 23-bit x
  localparam logic [23:0] DIV5_RECIP = 24'd13421773;

  typedef struct packed {
    logic [7:0]  valid_range_cm;
    logic [7:0]  danger_range_cm;
    logic [14:0] max_speed;
    logic [9:0]  ratio_diff_limit;
    logic [15:0] turn_gain;
    logic [7:0]  default_wall_cm;
    logic [8:0]  max_width_cm;
    logic [15:0] avoid_gain;
  } cfg_t;

  typedef struct packed {
    logic [8:0]  sum;
    logic [7:0]  diff;
    logic        fwd;
    logic        ok;
    logic [15:0] prod;
    logic [49:0] rad;
    logic [26:0] sq_rem;
    logic [24:0] sq_root;
    logic [9:0]  r_src;
    logic [8:0]  r_rem;
    logic [9:0]  ratio;
    logic [15:0] c_src;
    logic [8:0]  c_rem;
    logic [15:0] center;
  } cpl_t;

  typedef struct packed {
    logic [15:0]        front_mm;
    logic [15:0]        back_mm;
    logic [15:0]        left_mm;
    logic [15:0]        right_mm;
    logic               en;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yaw;
    logic [7:0]         cm_f;
    logic [7:0]         cm_b;
    logic [7:0]         cm_l;
    logic [7:0]         cm_r;
    cpl_t [1:0]         cp;
    logic               dl;
    logic               dr;
    logic               df;
    logic               db;
    logic [13:0]        half;
    logic [29:0]        y_rad;
    logic [16:0]        y_rem;
    logic [14:0]        y_root;
    logic [1:0]         side;
    logic [17:0]        turn;
    logic               turn_neg;
    logic [15:0]        goal;
    logic [15:0]        mainq;
    logic               err_neg;
    logic [15:0]        emag;
    logic [22:0]        d_src;
    logic [23:0]        quo;
    logic               rep;
  } ctx_t;

endpackage

@@ rtl/wfac_pipe.sv @@
`timescale 1ns / 1ps

module wfac_pipe (
  input  logic           clk,
  input  logic           rst,
  input  wfac_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  wfac_pkg::ctx_t in_ctx,
  output logic           out_valid,
  input  logic           out_ready,
  output wfac_pkg::ctx_t out_ctx
);
  import wfac_pkg::*;

  ctx_t             pipe [NUM_STAGES+1];
  ctx_t             nxt  [NUM_STAGES];
  logic [NUM_STAGES:0] vld;
  logic [NUM_STAGES:0] adv;

  function automatic logic [7:0] to_cm(input logic [15:0] mm);
    logic [32:0] p;
    logic [13:0] q;
    p = mm * CM_RECIP;
    q = p[32:19];
    return (q > 14'd255) ? 8'hFF : q[7:0];
  endfunction

  function automatic cpl_t make_cpl(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] vr);
    cpl_t r;
    r       = '0;
    r.sum   = {1'b0, a} + {1'b0, b};
    r.diff  = (a >= b) ? a - b : b - a;
    r.fwd   = (a >= b);
    r.ok    = (a != 8'd0) && (a < vr) && (b != 8'd0) && (b < vr);
    r.prod  = a * b;
    r.r_rem = {2'b00, r.diff[7:1]};
    r.r_src = {r.diff[0], 9'd0};
    return r;
  endfunction

  function automatic cpl_t sq_step(input cpl_t c);
    logic [28:0] rs;
    logic [26:0] tr;
    rs = {c.sq_rem, c.rad[49:48]};
    tr = {c.sq_root, 2'b01};
    if (rs >= {2'b00, tr}) begin
      c.sq_rem  = 27'(rs - {2'b00, tr});
      c.sq_root = {c.sq_root[23:0], 1'b1};
    end else begin
      c.sq_rem  = rs[26:0];
      c.sq_root = {c.sq_root[23:0], 1'b0};
    end
    c.rad = {c.rad[47:0], 2'b00};
    return c;
  endfunction

  function automatic cpl_t ratio_step(input cpl_t c);
    logic [9:0] rs;
    rs = {c.r_rem, c.r_src[9]};
    if (rs >= {1'b0, c.sum}) begin
      c.r_rem = 9'(rs - {1'b0, c.sum});
      c.ratio = {c.ratio[8:0], 1'b1};
    end else begin
      c.r_rem = rs[8:0];
      c.ratio = {c.ratio[8:0], 1'b0};
    end
    c.r_src = {c.r_src[8:0], 1'b0};
    return c;
  endfunction

  function automatic cpl_t cdiv_step(input cpl_t c);
    logic [9:0] rs;
    rs = {c.c_rem, c.c_src[15]};
    if (rs >= {1'b0, c.sum}) begin
      c.c_rem  = 9'(rs - {1'b0, c.sum});
      c.center = {c.center[14:0], 1'b1};
    end else begin
      c.c_rem  = rs[8:0];
      c.center = {c.center[14:0], 1'b0};
    end
    c.c_src = {c.c_src[14:0], 1'b0};
    return c;
  endfunction

  function automatic ctx_t iter_step(input ctx_t c, input int t);
    logic [18:0] rs;
    logic [16:0] tr;
    if (t < SQ_STEPS) begin
      c.cp[0] = sq_step(c.cp[0]);
      c.cp[1] = sq_step(c.cp[1]);
    end
    if (t < REP_STEPS) begin
      rs = {c.y_rem, c.y_rad[29:28]};
      tr = {c.y_root, 2'b01};
      if (rs >= {2'b00, tr}) begin
        c.y_rem  = 17'(rs - {2'b00, tr});
        c.y_root = {c.y_root[13:0], 1'b1};
      end else begin
        c.y_rem  = rs[16:0];
        c.y_root = {c.y_root[13:0], 1'b0};
      end
      c.y_rad = {c.y_rad[27:0], 2'b00};
    end
    if (t < RATIO_STEPS) begin
      c.cp[0] = ratio_step(c.cp[0]);
      c.cp[1] = ratio_step(c.cp[1]);
    end
    if (t >= SQ_STEPS && t < SQ_STEPS + CDIV_STEPS) begin
      if (t == SQ_STEPS) begin
        for (int j = 0; j < 2; j++) begin
          c.cp[j].c_rem  = c.cp[j].sq_root[24:16];
          c.cp[j].c_src  = c.cp[j].sq_root[15:0];
          c.cp[j].center = '0;
        end
      end
      c.cp[0] = cdiv_step(c.cp[0]);
      c.cp[1] = cdiv_step(c.cp[1]);
    end
    return c;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sh7FFF;
    if (v < -19'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] rep_val(input logic signed [2:0] k,
                                                 input logic [14:0] r);
    logic [2:0]  a;
    logic [15:0] m;
    a = k[2] ? 3'(-k) : k;
    if (a == 3'd2)      m = {1'b0, r};
    else if (a == 3'd1) m = {2'b00, r[14:1]};
    else                m = '0;
    return k[2] ? 16'(-m) : m;
  endfunction

  function automatic ctx_t stage_fn(input int s, input ctx_t c, input cfg_t k);
    logic [31:0]        psq;
    logic [27:0]        h2;
    logic [9:0]         rd;
    cpl_t               w;
    cpl_t               o;
    logic [25:0]        tp;
    logic [16:0]        csum;
    logic signed [18:0] ys;
    logic signed [18:0] ts;
    logic signed [16:0] e;
    logic [31:0]        ag;
    logic [46:0]        qp;
    logic               pos;
    logic signed [15:0] vyw;
    logic signed [2:0]  lrk;
    logic signed [2:0]  fbk;
    if (s == 0) begin
      c.cm_f = to_cm(c.front_mm);
      c.cm_b = to_cm(c.back_mm);
      c.cm_l = to_cm(c.left_mm);
      c.cm_r = to_cm(c.right_mm);
    end else if (s == 1) begin
      c.cp[0] = make_cpl(c.cm_l, c.cm_f, k.valid_range_cm);
      c.cp[1] = make_cpl(c.cm_r, c.cm_b, k.valid_range_cm);
      c.dl    = c.cm_l < k.danger_range_cm;
      c.dr    = c.cm_r < k.danger_range_cm;
      c.df    = c.cm_f < k.danger_range_cm;
      c.db    = c.cm_b < k.danger_range_cm;
      c.half  = k.max_speed[14:1];
    end else if (s == 2) begin
      for (int j = 0; j < 2; j++) begin
        psq               = c.cp[j].prod * c.cp[j].prod;
        c.cp[j].rad       = {1'b0, psq, 17'd0};
        c.cp[j].sq_rem    = '0;
        c.cp[j].sq_root   = '0;
      end
      h2       = c.half * c.half;
      c.y_rad  = {1'b0, h2, 1'b0};
      c.y_rem  = '0;
      c.y_root = '0;
    end else if (s < ST_CHOOSE) begin
      for (int j = 0; j < STEPS_PER; j++)
        c = iter_step(c, STEPS_PER * (s - PRE_STAGES) + j);
    end else if (s == ST_CHOOSE) begin
      for (int j = 0; j < 2; j++) begin
        if (c.cp[j].sum == 9'd0) begin
          c.cp[j].ratio  = '0;
          c.cp[j].center = '0;
        end
      end
      rd = (c.cp[0].ratio >= c.cp[1].ratio) ? c.cp[0].ratio - c.cp[1].ratio
                                            : c.cp[1].ratio - c.cp[0].ratio;
      if (!c.en)
        c.side = SIDE_NONE;
      else if (c.cp[0].ok && c.cp[1].ok) begin
        if (rd >= k.ratio_diff_limit)
          c.side = (c.cp[0].ratio <= c.cp[1].ratio) ? SIDE_LEFT : SIDE_RIGHT;
        else
          c.side = (c.cp[0].center <= c.cp[1].center) ? SIDE_LEFT : SIDE_RIGHT;
      end else if (c.cp[1].ok)
        c.side = SIDE_RIGHT;
      else if (c.cp[0].ok)
        c.side = SIDE_LEFT;
      else
        c.side = SIDE_NONE;
    end else if (s == ST_SELECT) begin
      w          = (c.side == SIDE_RIGHT) ? c.cp[1] : c.cp[0];
      o          = (c.side == SIDE_RIGHT) ? c.cp[0] : c.cp[1];
      tp         = k.turn_gain * w.ratio;
      c.turn     = tp[25:8];
      c.turn_neg = !w.fwd;
      csum       = {1'b0, w.center} + {1'b0, o.center};
      if (o.ok && csum <= {k.max_width_cm, 8'h00})
        c.goal = csum[16:1];
      else
        c.goal = {k.default_wall_cm, 8'h00};
      c.mainq = w.center;
    end else if (s == ST_ERROR) begin
      ys = 19'(c.yaw);
      ts = $signed({1'b0, c.turn});
      if (c.side != SIDE_NONE)
        c.yaw = sat16(c.turn_neg ? ys - ts : ys + ts);
      e         = $signed({1'b0, c.goal}) - $signed({1'b0, c.mainq});
      c.err_neg = e[16];
      c.emag    = e[16] ? 16'(-e) : e[15:0];
    end else if (s == ST_GAIN) begin
      ag      = k.avoid_gain * c.emag;
      c.d_src = ag[31:9];
    end else if (s == ST_DIV5_0) begin
      qp    = c.d_src * DIV5_RECIP;
      c.quo = {3'b000, qp[46:26]};
    end else begin
      pos = (c.side == SIDE_RIGHT) ^ c.err_neg;
      if (pos)
        vyw = (c.quo > 24'd32767) ? 16'sh7FFF : c.quo[15:0];
      else
        vyw = (c.quo > 24'd32768) ? 16'sh8000 : 16'(24'd0 - c.quo);
      if (c.side != SIDE_NONE)
        c.vy = vyw;
      lrk = $signed({2'b00, c.dr}) - $signed({2'b00, c.dl});
      fbk = $signed({2'b00, c.db}) - $signed({2'b00, c.df});
      if (c.en && c.half != 14'd0 && (lrk != 3'sd0 || fbk != 3'sd0)) begin
        c.vx  = rep_val(3'(fbk - lrk), c.y_root);
        c.vy  = rep_val(3'(fbk + lrk), c.y_root);
        c.rep = 1'b1;
      end
    end
    return c;
  endfunction

  assign adv[NUM_STAGES] = !vld[NUM_STAGES] || out_ready;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    assign adv[i] = !vld[i] || adv[i+1];
    always_comb begin
      nxt[i] = stage_fn(i, pipe[i], cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (adv[i+1]) vld[i+1] <= vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) pipe[0] <= in_ctx;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (adv[i+1]) pipe[i+1] <= nxt[i];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NUM_STAGES];
  assign out_ctx   = pipe[NUM_STAGES];

endmodule

@@ rtl/wall_follow_avoid_controller_unit.sv @@
`timescale 1ns / 1ps
// Wall-following and collision-avoidance controller.
// Input stream (s_*): one request per beat carries four ranger distances in mm,
// the enable flag and the vx, vy and yaw-rate setpoints. Output stream (m_*):
// one result per request, in order: corrected vx, vy, yaw rate, followed wall
// and a repulsion flag. The cfg_* channel writes the eight tuning registers by
// index; cfg_ready is always high, and writes belong in idle periods.
// An accepted request passes through one input register plus 30 stages: cm
// conversion, couple setup, squares, 21 stages of two square-root / divide
// digits each, then wall choice, wall select, yaw and error, gain, a divide
// by five by reciprocal multiply, and the output stage.
// Throughput is one request per cycle while m_tready stays high; the
// digit-serial square root and divider are fully unrolled across stages.
// Every stage has its own valid bit; a stage holds only when the stage after
// it is full and held, so a stalled receiver fills the bubbles first and
// s_tready drops only once all 31 registers are full. Nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and restores register defaults.
module wall_follow_avoid_controller_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // front_mm, back_mm, left_mm, right_mm, enable, vx_in, vy_in, yaw_rate_in
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vx_out, vy_out, yaw_rate_out, wall_side, repulsing
  output logic [55:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import wfac_pkg::*;

  cfg_t cfg;
  ctx_t in_ctx;
  ctx_t out_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_range_cm   <= 8'd150;
      cfg.danger_range_cm  <= 8'd20;
      cfg.max_speed        <= 15'd128;
      cfg.ratio_diff_limit <= 10'd128;
      cfg.turn_gain        <= 16'd256;
      cfg.default_wall_cm  <= 8'd40;
      cfg.max_width_cm     <= 9'd200;
      cfg.avoid_gain       <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VALID_RANGE:  cfg.valid_range_cm   <= cfg_data[7:0];
        REG_DANGER_RANGE: cfg.danger_range_cm  <= cfg_data[7:0];
        REG_MAX_SPEED:    cfg.max_speed        <= cfg_data[14:0];
        REG_RATIO_LIMIT:  cfg.ratio_diff_limit <= cfg_data[9:0];
        REG_TURN_GAIN:    cfg.turn_gain        <= cfg_data;
        REG_DEFAULT_WALL: cfg.default_wall_cm  <= cfg_data[7:0];
        REG_MAX_WIDTH:    cfg.max_width_cm     <= cfg_data[8:0];
        REG_AVOID_GAIN:   cfg.avoid_gain       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    in_ctx          = '0;
    in_ctx.front_mm = s_tdata[15:0];
    in_ctx.back_mm  = s_tdata[31:16];
    in_ctx.left_mm  = s_tdata[47:32];
    in_ctx.right_mm = s_tdata[63:48];
    in_ctx.en       = s_tdata[64];
    in_ctx.vx       = s_tdata[80:65];
    in_ctx.vy       = s_tdata[96:81];
    in_ctx.yaw      = s_tdata[112:97];
    in_ctx.side     = SIDE_NONE;
  end

  wfac_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ctx    (in_ctx),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ctx   (out_ctx)
  );

  assign m_tdata = {5'd0, out_ctx.rep, out_ctx.side, out_ctx.yaw, out_ctx.vy, out_ctx.vx};

endmodule

@@ dv/wall_follow_avoid_controller_unit_checker.sv @@
`timescale 1ns / 1ps

module wall_follow_avoid_controller_unit_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [119:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [55:0]  m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           errors,
  output int           pending
);
  import wfac_pkg::*;

  typedef struct packed {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] yaw;
    logic [1:0]  side;
    logic        rep;
  } cmd_t;

  typedef struct {
    longint d1;
    longint d2;
    longint ratio;
    longint center;
    bit     fwd;
    bit     ok;
  } couple_t;

  cfg_t   regs;
  cmd_t   cmd_q[$];

  function automatic longint isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint to_cm(logic [15:0] mm);
    longint c;
    c = mm / 10;
    return c > 255 ? 255 : c;
  endfunction

  function automatic longint sat(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint inv_sqrt2(longint x);
    longint m;
    m = x < 0 ? -x : x;
    m = isqrt((m * m) / 2);
    return x < 0 ? -m : m;
  endfunction

  function automatic couple_t form_couple(longint a, longint b);
    couple_t p;
    longint s, d, pr;
    s = a + b;
    d = a >= b ? a - b : b - a;
    pr = a * b;
    p.d1 = a;
    p.d2 = b;
    p.fwd = a >= b;
    p.ok = a > 0 && a < regs.valid_range_cm && b > 0 && b < regs.valid_range_cm;
    p.ratio = 0;
    p.center = 0;
    if (s != 0) begin
      p.ratio = (d * 512) / s;
      p.center = isqrt((2 * 65536 * pr * pr) / (s * s));
    end
    return p;
  endfunction

  function automatic cmd_t steer(logic [119:0] d);
    cmd_t r;
    couple_t cp[2];
    couple_t w, o;
    longint fr, bk, lf, rt, vx, vy, yaw, rd, turn, goal, err, mag, half, lr, fb;
    logic [1:0] side;
    bit rep;
    fr = to_cm(d[15:0]);
    bk = to_cm(d[31:16]);
    lf = to_cm(d[47:32]);
    rt = to_cm(d[63:48]);
    vx = longint'($signed(d[80:65]));
    vy = longint'($signed(d[96:81]));
    yaw = longint'($signed(d[112:97]));
    side = SIDE_NONE;
    rep = 0;
    cp[0] = form_couple(lf, fr);
    cp[1] = form_couple(rt, bk);
    if (d[64]) begin
      if (cp[0].ok && cp[1].ok) begin
        rd = cp[0].ratio >= cp[1].ratio ? cp[0].ratio - cp[1].ratio
                                        : cp[1].ratio - cp[0].ratio;
        if (rd >= regs.ratio_diff_limit)
          side = cp[0].ratio <= cp[1].ratio ? SIDE_LEFT : SIDE_RIGHT;
        else
          side = cp[0].center <= cp[1].center ? SIDE_LEFT : SIDE_RIGHT;
      end else if (cp[1].ok) begin
        side = SIDE_RIGHT;
      end else if (cp[0].ok) begin
        side = SIDE_LEFT;
      end
      if (side != SIDE_NONE) begin
        w = cp[side[0]];
        o = cp[!side[0]];
        turn = (longint'(regs.turn_gain) * w.ratio) >>> 8;
        yaw = sat(yaw + (w.fwd ? turn : -turn));
        goal = longint'(regs.default_wall_cm) * 256;
        if (o.ok && w.center + o.center <= longint'(regs.max_width_cm) * 256)
          goal = (w.center + o.center) >>> 1;
        err = goal - w.center;
        mag = (longint'(regs.avoid_gain) * (err < 0 ? -err : err)) / 2560;
        if (err < 0) mag = -mag;
        vy = sat(side == SIDE_RIGHT ? mag : -mag);
      end
      half = regs.max_speed >> 1;
      lr = 0;
      fb = 0;
      if (lf < regs.danger_range_cm) lr -= half;
      if (rt < regs.danger_range_cm) lr += half;
      if (fr < regs.danger_range_cm) fb -= half;
      if (bk < regs.danger_range_cm) fb += half;
      if (lr != 0 || fb != 0) begin
        vx = sat(inv_sqrt2(fb - lr));
        vy = sat(inv_sqrt2(fb + lr));
        rep = 1;
      end
    end
    r.vx = vx[15:0];
    r.vy = vy[15:0];
    r.yaw = yaw[15:0];
    r.side = side;
    r.rep = rep;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = cmd_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    cmd_t want;
    if (rst) begin
      regs <= '{8'd150, 8'd20, 15'd128, 10'd128, 16'd256, 8'd40, 9'd200, 16'd256};
      cmd_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VALID_RANGE:  regs.valid_range_cm <= cfg_data[7:0];
          REG_DANGER_RANGE: regs.danger_range_cm <= cfg_data[7:0];
          REG_MAX_SPEED:    regs.max_speed <= cfg_data[14:0];
          REG_RATIO_LIMIT:  regs.ratio_diff_limit <= cfg_data[9:0];
          REG_TURN_GAIN:    regs.turn_gain <= cfg_data;
          REG_DEFAULT_WALL: regs.default_wall_cm <= cfg_data[7:0];
          REG_MAX_WIDTH:    regs.max_width_cm <= cfg_data[8:0];
          REG_AVOID_GAIN:   regs.avoid_gain <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) cmd_q.push_back(steer(s_tdata));
      if (m_tvalid && m_tready) begin
        if (cmd_q.size() == 0) begin
          report("unexpected result", m_tdata, 0);
        end else begin
          want = cmd_q.pop_front();
          if (m_tdata[15:0] != want.vx) report("vx_out", m_tdata[15:0], want.vx);
          if (m_tdata[31:16] != want.vy) report("vy_out", m_tdata[31:16], want.vy);
          if (m_tdata[47:32] != want.yaw) report("yaw_rate_out", m_tdata[47:32], want.yaw);
          if (m_tdata[49:48] != want.side) report("wall_side", m_tdata[49:48], want.side);
          if (m_tdata[50] != want.rep) report("repulsing", m_tdata[50], want.rep);
        end
      end
    end
  end

endmodule

@@ dv/wall_follow_avoid_controller_unit_test.sv @@
`timescale 1ns / 1ps

module wall_follow_avoid_controller_unit_test;
  import wfac_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [55:0]  m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  int           errors;
  int           pending;
  int           idle_cycles = 0;

  always #4 clk = ~clk;

  wall_follow_avoid_controller_unit u_top (.*);
  wall_follow_avoid_controller_unit_checker u_chk (.*);

  function automatic int gap();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 30);
  endfunction

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("wall_follow_avoid_controller_unit: mismatch");
      $finish;
    end
  end

  // receiver stalls, with calm stretches
  initial begin
    int calm;
    calm = 0;
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        calm--;
        m_tready <= 1;
      end else if ($urandom_range(0, 99) < 2) begin
        calm = $urandom_range(20, 80);
      end else begin
        m_tready <= (gap() == 0);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send(logic [15:0] f, logic [15:0] b, logic [15:0] l, logic [15:0] r,
                      logic en, logic [15:0] vx, logic [15:0] vy, logic [15:0] yaw,
                      bit hurry);
    int g;
    g = hurry ? 0 : gap();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tdata <= {7'd0, yaw, vy, vx, en, r, l, b, f};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_mm();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 9));
      1: return 16'($urandom_range(0, 300));
      2: return 16'($urandom_range(0, 2600));
      3: return 16'($urandom());
      default: return 16'($urandom_range(50, 1600));
    endcase
  endfunction

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic random_phase(int n);
    bit burst;
    for (int i = 0; i < n; i++) begin
      burst = (i % 100) < 20;
      send(rand_mm(), rand_mm(), rand_mm(), rand_mm(), $urandom_range(0, 9) != 0,
           16'($urandom()), 16'($urandom()), 16'($urandom()), burst);
    end
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send(0, 0, 0, 0, 1, 16'h7fff, 16'h8000, 16'h1234, 0);
    send(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 16'h8000, 16'h7fff, 16'hffff, 0);
    send(500, 800, 400, 600, 0, 16'h0100, 16'hff00, 16'h0080, 0);
    send(500, 800, 400, 600, 1, 16'h0100, 16'hff00, 16'h0080, 0);
    send(300, 600, 1000, 350, 1, 16'h7fff, 16'h8000, 16'h7fff, 0);
    send(1000, 600, 300, 1400, 1, 0, 0, 16'h8000, 0);
    send(400, 400, 400, 400, 1, 0, 0, 0, 0);
    send(2000, 2000, 300, 2000, 1, 0, 0, 0, 0);
    send(2000, 2000, 2000, 300, 1, 0, 0, 0, 0);
    send(150, 500, 500, 500, 1, 0, 0, 0, 0);
    send(500, 150, 500, 500, 1, 0, 0, 0, 0);
    send(500, 500, 150, 500, 1, 0, 0, 0, 0);
    send(500, 500, 500, 150, 1, 0, 0, 0, 0);
    send(150, 150, 150, 150, 1, 0, 0, 0, 0);
    send(1499, 1500, 1490, 10, 1, 0, 0, 0, 0);
    send(9, 19, 10, 199, 1, 16'h5555, 16'haaaa, 16'h5555, 0);
    drain();
    write_reg(REG_VALID_RANGE, 16'hff);
    write_reg(REG_DANGER_RANGE, 16'hff);
    write_reg(REG_MAX_SPEED, 16'h7fff);
    write_reg(REG_RATIO_LIMIT, 16'h3ff);
    write_reg(REG_TURN_GAIN, 16'hffff);
    write_reg(REG_DEFAULT_WALL, 16'hff);
    write_reg(REG_MAX_WIDTH, 16'h1ff);
    write_reg(REG_AVOID_GAIN, 16'hffff);
    random_phase(120);
    write_reg(REG_DANGER_RANGE, 0);
    random_phase(120);
    write_reg(REG_VALID_RANGE, 0);
    write_reg(REG_MAX_SPEED, 0);
    write_reg(REG_RATIO_LIMIT, 0);
    write_reg(REG_TURN_GAIN, 0);
    write_reg(REG_DEFAULT_WALL, 0);
    write_reg(REG_MAX_WIDTH, 0);
    write_reg(REG_AVOID_GAIN, 0);
    random_phase(60);
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 8; k++) write_reg(k[2:0], 16'($urandom()));
      write_reg(REG_VALID_RANGE, 16'($urandom_range(60, 255)));
      random_phase(110);
    end
    if (errors == 0) begin
      $display("wall_follow_avoid_controller_unit: match");
    end else begin
      $display("wall_follow_avoid_controller_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wfac_pkg.sv
rtl/wfac_pipe.sv
rtl/wall_follow_avoid_controller_unit.sv
dv/wall_follow_avoid_controller_unit_checker.sv
dv/wall_follow_avoid_controller_unit_test.sv
